FILE: hw/rtl/assert_macros.svh
// Assertion helper macros shared by the tour two-opt RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

FILE: hw/rtl/tto_pkg.sv
// Shared types and constants of the tour two-opt block.
// Used by tto_dist and tour_two_opt_pass; depends on nothing.
`default_nettype none

package tto_pkg;

    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_COORD_BITS = 16;

    // distance = floor(sqrt(d2 << DIST_SHIFT)), 8 fraction bits
    localparam int DIST_SHIFT = 16;

    localparam int IDX_W  = 10;
    localparam int CRD_W  = 16;
    localparam int NODE_W = 10;
    localparam int CNT_W  = 11;
    localparam int END_W  = 11;
    localparam int GAIN_W = 26;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    // input tdata layout, lowest bit first
    localparam int IDX_LO    = 0;
    localparam int X_LO      = IDX_LO + IDX_W;
    localparam int Y_LO      = X_LO + CRD_W;
    localparam int NODE_LO   = Y_LO + CRD_W;
    localparam int FIRST_LO  = NODE_LO + NODE_W;
    localparam int END_LO    = FIRST_LO + IDX_W;
    localparam int IN_DATA_W = 80;

    // output tdata layout, lowest bit first
    localparam int OUT_GAIN_LO = 1;
    localparam int OUT_NODE_LO = OUT_GAIN_LO + GAIN_W;
    localparam int OUT_DATA_W  = 40;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_TOUR  = 2'd1,
        KIND_PASS  = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tto_dist.sv
// Euclidean distance unit: abs difference, squares, then a bit-serial square root.
// Depends on tto_pkg and assert_macros.svh.
`default_nettype none

module tto_dist #(
    parameter int COORD_BITS = tto_pkg::DEF_COORD_BITS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          start,
    input  logic [COORD_BITS-1:0]                         ax,
    input  logic [COORD_BITS-1:0]                         ay,
    input  logic [COORD_BITS-1:0]                         bx,
    input  logic [COORD_BITS-1:0]                         by,
    output logic                                          busy,
    output logic                                          done,
    output logic [COORD_BITS+tto_pkg::DIST_SHIFT/2:0]     dist_out
);
    import tto_pkg::*;

    `include "assert_macros.svh"

    localparam int DW   = COORD_BITS + DIST_SHIFT/2 + 1;
    localparam int RE   = 2 * DW;
    localparam int RMW  = DW + 2;
    localparam int CNTW = $clog2(DW + 1);

    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [RE-1:0]         rad_reg;
    logic [RMW-1:0]        rem_reg;
    logic [DW-1:0]         root_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  sq_pend_reg, iter_reg, done_reg;

    logic [RMW+1:0] rem_sh, trial;
    logic           take;
    logic [2*COORD_BITS:0] sum_sq;

    assign sum_sq = (2*COORD_BITS+1)'(dx_reg * dx_reg) + (2*COORD_BITS+1)'(dy_reg * dy_reg);
    assign rem_sh = {rem_reg, rad_reg[RE-1:RE-2]};
    assign trial  = (RMW+2)'({root_reg, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_pend_reg <= 1'b0;
            iter_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            done_reg    <= 1'b0;
            sq_pend_reg <= start;
            if (sq_pend_reg) begin
                iter_reg <= 1'b1;
            end else if (iter_reg && cnt_reg == CNTW'(DW - 1)) begin
                iter_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dx_reg <= (ax > bx) ? ax - bx : bx - ax;
            dy_reg <= (ay > by) ? ay - by : by - ay;
        end
        if (sq_pend_reg) begin
            rad_reg  <= RE'(sum_sq) << DIST_SHIFT;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
        end else if (iter_reg) begin
            // one root bit per cycle, restoring form
            rem_reg  <= take ? RMW'(rem_sh - trial) : RMW'(rem_sh);
            root_reg <= {root_reg[DW-2:0], take};
            rad_reg  <= rad_reg << 2;
            cnt_reg  <= cnt_reg + CNTW'(1);
        end
    end

    assign busy     = sq_pend_reg | iter_reg;
    assign done     = done_reg;
    assign dist_out = root_reg;

    `ASSERT_CLK(a_start_sets_busy, aclk, aresetn, start |=> busy, "dist: start did not run")
    `ASSERT_NEVER(a_done_while_busy, aclk, aresetn, done && busy, "dist: done while busy")
    `ASSERT_NEVER(a_start_while_busy, aclk, aresetn, start && busy, "dist: restart while busy")

endmodule

`default_nettype wire

FILE: hw/rtl/tour_two_opt_pass.sv
// Top level of the tour two-opt block: stores, pass sequencer, result register.
// Depends on tto_pkg, tto_dist and assert_macros.svh.
`default_nettype none

// Holds node coordinates and a closed tour in on-chip memories with a
// registered read, and runs one 2-opt pass on command: the pass applies
// the best j of the first start position i that improves, then ends.
// Every input item gives exactly one result item. Point and tour writes
// go straight to the result stage; a tour read passes through S_RD first.
// A pass first rebuilds the edge-length memory (n distances), then for
// each start position i scans the candidate j positions; each candidate
// costs two distances. All distances go through one shared distance unit
// with a bit-serial square root. A pass over n nodes scans up to about
// n*n candidates, plus the reversal, which swaps one pair of positions
// per round of S_REV, S_REV_RD and S_REV_W2. The square root unit sets
// the rate. The block takes one item at a time; a finished result waits
// in the output register while the next item is taken. The memories have
// no clearing pass: the user must write point and tour entries before
// they are read, which the block itself does not enforce; the edge
// memory is written by each pass's rebuild before it is read.
module tour_two_opt_pass #(
    parameter int MAX_NODES  = tto_pkg::DEF_MAX_NODES,
    parameter int COORD_BITS = tto_pkg::DEF_COORD_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // index, coord_x, coord_y, node, pass_first, pass_end (from bit 0), zero padded
    input  logic [tto_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // improved, gain, read_node (from bit 0), zero padded
    output logic [tto_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [tto_pkg::CNT_W-1:0]          cfg_wr_data
);
    import tto_pkg::*;

    `include "assert_macros.svh"

    localparam int AW  = $clog2(MAX_NODES);
    localparam int CW0 = $clog2(MAX_NODES + 1);
    localparam int PW  = ((CW0 > END_W) ? CW0 : END_W) + 1;
    localparam int DW  = COORD_BITS + DIST_SHIFT/2 + 1;
    localparam int GW  = DW + 3;

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_RD      = 21'h000002,
        S_SETUP   = 21'h000004,
        S_E_TOUR  = 21'h000008,
        S_E_PT    = 21'h000010,
        S_E_GO    = 21'h000020,
        S_E_WAIT  = 21'h000040,
        S_I_TOUR  = 21'h000080,
        S_I_LATCH = 21'h000100,
        S_J_CHK   = 21'h000200,
        S_J_TOUR  = 21'h000400,
        S_J_PT    = 21'h000800,
        S_J_D1    = 21'h001000,
        S_J_W1    = 21'h002000,
        S_J_D2    = 21'h004000,
        S_J_W2    = 21'h008000,
        S_I_NEXT  = 21'h010000,
        S_REV     = 21'h020000,
        S_REV_RD  = 21'h040000,
        S_REV_W2  = 21'h080000,
        S_DONE    = 21'h100000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    kind_t              in_kind;
    logic [IDX_W-1:0]   in_index;
    logic [CRD_W-1:0]   in_coord_x, in_coord_y;
    logic [NODE_W-1:0]  in_node;
    logic [IDX_W-1:0]   in_first;
    logic [END_W-1:0]   in_end;
    logic               in_idx_ok;

    assign in_kind    = kind_t'(s_tuser);
    assign in_index   = s_tdata[IDX_LO +: IDX_W];
    assign in_coord_x = s_tdata[X_LO +: CRD_W];
    assign in_coord_y = s_tdata[Y_LO +: CRD_W];
    assign in_node    = s_tdata[NODE_LO +: NODE_W];
    assign in_first   = s_tdata[FIRST_LO +: IDX_W];
    assign in_end     = s_tdata[END_LO +: END_W];
    assign in_idx_ok  = (PW'(in_index) < PW'(MAX_NODES));

    // configuration
    logic [CNT_W-1:0] node_count_reg;

    // memories and their registered read data
    logic [COORD_BITS-1:0] px_mem [MAX_NODES];
    logic [COORD_BITS-1:0] py_mem [MAX_NODES];
    logic [NODE_W-1:0]     tour_mem [MAX_NODES];
    logic [DW-1:0]         edge_mem [MAX_NODES];

    logic [COORD_BITS-1:0] pxa_q, pya_q, pxb_q, pyb_q;
    logic [NODE_W-1:0]     tour_a_q, tour_b_q;
    logic [DW-1:0]         edge_q;
    logic                  na_ok_reg, nb_ok_reg;

    logic              pt_we, tour_we, edge_we;
    logic [AW-1:0]     tour_waddr, tour_ra, tour_rb, edge_ra;
    logic [NODE_W-1:0] tour_wdata;
    logic [NODE_W-1:0] node_a, node_b;

    // pass registers
    logic [PW-1:0] n_reg, first_reg, end_reg, p_reg, i_reg, j_reg, bestj_reg;
    logic [PW-1:0] lo_reg, hi_reg;
    logic [NODE_W-1:0] ti_reg, ti1_reg, tj1_reg, swap_reg;
    logic [DW-1:0]     ei_reg, ej_reg, d1_reg;
    logic [DW:0]       best_reg;
    logic              rd_ok_reg;

    // result registers
    logic              res_improved_reg;
    logic [GAIN_W-1:0] res_gain_reg;
    logic [NODE_W-1:0] res_node_reg;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // distance unit
    logic                  dist_start, dist_busy, dist_done;
    logic [DW-1:0]         dist_val;
    logic [COORD_BITS-1:0] crd_ax, crd_ay, crd_bx, crd_by;

    logic [PW-1:0]        n_clamp, end_eff;
    logic signed [GW-1:0] gain_c;
    logic                 pair_ok;

    function automatic logic [PW-1:0] succ_pos(input logic [PW-1:0] p, input logic [PW-1:0] n);
        return (p + PW'(1) >= n) ? '0 : p + PW'(1);
    endfunction

    assign n_clamp = (PW'(node_count_reg) < PW'(3)) ? PW'(3) :
                     (PW'(node_count_reg) > PW'(MAX_NODES)) ? PW'(MAX_NODES) :
                     PW'(node_count_reg);
    assign end_eff = (end_reg > n_reg) ? n_reg : end_reg;

    // skip j next to i: only j+1 < i or j > i+1 pass; the wrap pair 0 and n-1 is not skipped
    assign pair_ok = (j_reg + PW'(1) < i_reg) || (j_reg > i_reg + PW'(1));

    assign gain_c = $signed(GW'(ei_reg)) + $signed(GW'(ej_reg))
                  - $signed(GW'(d1_reg)) - $signed(GW'(dist_val));

    // out-of-range nodes sit at the origin
    assign crd_ax = na_ok_reg ? pxa_q : '0;
    assign crd_ay = na_ok_reg ? pya_q : '0;
    assign crd_bx = nb_ok_reg ? pxb_q : '0;
    assign crd_by = nb_ok_reg ? pyb_q : '0;

    tto_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (dist_start),
        .ax       (crd_ax),
        .ay       (crd_ay),
        .bx       (crd_bx),
        .by       (crd_by),
        .busy     (dist_busy),
        .done     (dist_done),
        .dist_out (dist_val)
    );

    // memory control and next state
    always_comb begin
        state_next = state_reg;
        pt_we      = 1'b0;
        tour_we    = 1'b0;
        edge_we    = 1'b0;
        tour_waddr = AW'(in_index);
        tour_wdata = in_node;
        tour_ra    = AW'(in_index);
        tour_rb    = '0;
        edge_ra    = '0;
        node_a     = '0;
        node_b     = '0;
        dist_start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (in_kind)
                        KIND_POINT: begin
                            pt_we      = in_idx_ok;
                            state_next = S_DONE;
                        end
                        KIND_TOUR: begin
                            tour_we    = in_idx_ok;
                            state_next = S_DONE;
                        end
                        KIND_PASS: state_next = S_SETUP;
                        KIND_READ: state_next = S_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_RD: state_next = S_DONE;
            S_SETUP: begin
                state_next = (first_reg >= end_eff) ? S_DONE : S_E_TOUR;
            end
            S_E_TOUR: begin
                tour_ra    = AW'(p_reg);
                tour_rb    = AW'(succ_pos(p_reg, n_reg));
                state_next = S_E_PT;
            end
            S_E_PT: begin
                node_a     = tour_a_q;
                node_b     = tour_b_q;
                state_next = S_E_GO;
            end
            S_E_GO: begin
                dist_start = 1'b1;
                state_next = S_E_WAIT;
            end
            S_E_WAIT: begin
                if (dist_done) begin
                    edge_we    = 1'b1;
                    state_next = (p_reg + PW'(1) >= n_reg) ? S_I_TOUR : S_E_TOUR;
                end
            end
            S_I_TOUR: begin
                tour_ra    = AW'(i_reg);
                tour_rb    = AW'(succ_pos(i_reg, n_reg));
                edge_ra    = AW'(i_reg);
                state_next = S_I_LATCH;
            end
            S_I_LATCH: state_next = S_J_CHK;
            S_J_CHK: begin
                if (j_reg >= n_reg) begin
                    state_next = S_I_NEXT;
                end else if (pair_ok) begin
                    state_next = S_J_TOUR;
                end
            end
            S_J_TOUR: begin
                tour_ra    = AW'(j_reg);
                tour_rb    = AW'(succ_pos(j_reg, n_reg));
                edge_ra    = AW'(j_reg);
                state_next = S_J_PT;
            end
            S_J_PT: begin
                node_a     = ti_reg;
                node_b     = tour_a_q;
                state_next = S_J_D1;
            end
            S_J_D1: begin
                dist_start = 1'b1;
                state_next = S_J_W1;
            end
            S_J_W1: begin
                node_a = ti1_reg;
                node_b = tj1_reg;
                if (dist_done) begin
                    state_next = S_J_D2;
                end
            end
            S_J_D2: begin
                dist_start = 1'b1;
                state_next = S_J_W2;
            end
            S_J_W2: begin
                if (dist_done) begin
                    state_next = S_J_CHK;
                end
            end
            S_I_NEXT: begin
                if (best_reg != '0) begin
                    state_next = S_REV;
                end else if (i_reg + PW'(1) >= end_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_I_TOUR;
                end
            end
            S_REV: begin
                tour_ra    = AW'(lo_reg);
                tour_rb    = AW'(hi_reg);
                state_next = (lo_reg < hi_reg) ? S_REV_RD : S_DONE;
            end
            S_REV_RD: begin
                tour_we    = 1'b1;
                tour_waddr = AW'(lo_reg);
                tour_wdata = tour_b_q;
                state_next = S_REV_W2;
            end
            S_REV_W2: begin
                tour_we    = 1'b1;
                tour_waddr = AW'(hi_reg);
                tour_wdata = swap_reg;
                state_next = S_REV;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memories: one write port, registered reads
    always_ff @(posedge aclk) begin
        if (pt_we) begin
            px_mem[AW'(in_index)] <= COORD_BITS'(in_coord_x);
            py_mem[AW'(in_index)] <= COORD_BITS'(in_coord_y);
        end
        pxa_q     <= px_mem[AW'(node_a)];
        pya_q     <= py_mem[AW'(node_a)];
        pxb_q     <= px_mem[AW'(node_b)];
        pyb_q     <= py_mem[AW'(node_b)];
        na_ok_reg <= (PW'(node_a) < PW'(MAX_NODES));
        nb_ok_reg <= (PW'(node_b) < PW'(MAX_NODES));
    end

    always_ff @(posedge aclk) begin
        if (tour_we) begin
            tour_mem[tour_waddr] <= tour_wdata;
        end
        tour_a_q <= tour_mem[tour_ra];
        tour_b_q <= tour_mem[tour_rb];
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[AW'(p_reg)] <= dist_val;
        end
        edge_q <= edge_mem[edge_ra];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // pass datapath and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                res_improved_reg <= 1'b0;
                res_gain_reg     <= '0;
                res_node_reg     <= '0;
                rd_ok_reg        <= in_idx_ok;
                first_reg        <= PW'(in_first);
                end_reg          <= PW'(in_end);
                n_reg            <= n_clamp;
            end
            S_RD: begin
                res_node_reg <= rd_ok_reg ? tour_a_q : '0;
            end
            S_SETUP: begin
                end_reg <= end_eff;
                p_reg   <= '0;
                i_reg   <= first_reg;
            end
            S_E_WAIT: begin
                if (dist_done) begin
                    p_reg <= p_reg + PW'(1);
                end
            end
            S_I_LATCH: begin
                ti_reg    <= tour_a_q;
                ti1_reg   <= tour_b_q;
                ei_reg    <= edge_q;
                j_reg     <= first_reg;
                best_reg  <= '0;
                bestj_reg <= '0;
            end
            S_J_CHK: begin
                if (j_reg < n_reg && !pair_ok) begin
                    j_reg <= j_reg + PW'(1);
                end
            end
            S_J_PT: begin
                tj1_reg <= tour_b_q;
                ej_reg  <= edge_q;
            end
            S_J_W1: begin
                if (dist_done) begin
                    d1_reg <= dist_val;
                end
            end
            S_J_W2: begin
                if (dist_done) begin
                    // keep the first j on a tie
                    if (gain_c > $signed(GW'(best_reg))) begin
                        best_reg  <= gain_c[DW:0];
                        bestj_reg <= j_reg;
                    end
                    j_reg <= j_reg + PW'(1);
                end
            end
            S_I_NEXT: begin
                if (best_reg != '0) begin
                    res_improved_reg <= 1'b1;
                    res_gain_reg     <= GAIN_W'(best_reg);
                    // reverse the tour positions from i+1 to j, or from j+1 to i
                    if (bestj_reg > i_reg) begin
                        lo_reg <= i_reg + PW'(1);
                        hi_reg <= bestj_reg;
                    end else begin
                        lo_reg <= bestj_reg + PW'(1);
                        hi_reg <= i_reg;
                    end
                end else begin
                    i_reg <= i_reg + PW'(1);
                end
            end
            S_REV_RD: begin
                swap_reg <= tour_a_q;
            end
            S_REV_W2: begin
                lo_reg <= lo_reg + PW'(1);
                hi_reg <= hi_reg - PW'(1);
            end
            default: begin
            end
        endcase
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= OUT_DATA_W'({res_node_reg, res_gain_reg, res_improved_reg});
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_NEVER(a_dist_overlap, aclk, aresetn, dist_start && dist_busy,
        "top: distance started while busy")
    `ASSERT_CLK(a_swap_in_range, aclk, aresetn, (state_reg == S_REV_RD) |-> (lo_reg < hi_reg),
        "top: swap with crossed bounds")
    `ASSERT_CLK(a_result_from_done, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE), "top: result without finish")

endmodule

`default_nettype wire
